// ===== rtl/core/c8ic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package c8ic_pkg;

  // Core sizing
  localparam int MEM_BYTES     = 4096;
  localparam int PROGRAM_START = 512;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_W      = 64;
  localparam int SCREEN_H      = 32;
  localparam int NUM_KEYS      = 16;

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int SW_W   = $clog2(SCREEN_W);
  localparam int SH_W   = $clog2(SCREEN_H);
  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // Request commands
  localparam logic [2:0] CMD_STEP     = 3'd0;
  localparam logic [2:0] CMD_WRITE    = 3'd1;
  localparam logic [2:0] CMD_KEY      = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_RESET_PC = 3'd4;

  // Result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNIMPL = 2'd1;
  localparam logic [1:0] ST_WRAP   = 2'd2;

  // Opcode constants
  localparam logic [15:0] OP_RETURN  = 16'h00EE;
  localparam logic [7:0]  OP_STORE   = 8'h55;
  localparam logic [7:0]  OP_LOAD    = 8'h65;
  localparam logic [7:0]  OP_KEYSKIP = 8'h9E;
  localparam logic [3:0]  GRP_DRAW   = 4'hD;
  localparam logic [3:0]  GRP_F      = 4'hF;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_MISC, S_F0, S_F1, S_F2, S_EXEC,
    S_DI, S_DD, S_DFIN, S_ST, S_LI, S_LD, S_OUT
  } c8ic_state_t;

  typedef enum logic [2:0] {
    MA_CLEAR, MA_ITEM, MA_PC, MA_PC1, MA_IDX
  } c8ic_msel_t;

  typedef struct packed {
    logic              accept;
    c8ic_msel_t        msel;
    logic              clear;
    logic              store;
    logic              cap_hi;
    logic              cap_lo;
    logic              exec;
    logic              draw_row;
    logic              draw_fin;
    logic              load_reg;
    logic              misc;
    logic              load_out;
    logic [3:0]        cnt;
    logic [MEM_AW-1:0] clr_addr;
  } c8ic_cmd_t;

  typedef struct packed {
    logic [15:0] op;
  } c8ic_stat_t;

  // 12-bit address onto the memory index
  function automatic logic [MEM_AW-1:0] mem_idx(input logic [11:0] a);
    logic [MEM_AW+11:0] t;
    t = {{MEM_AW{1'b0}}, a};
    return t[MEM_AW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/c8ic_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface c8ic_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [11:0] address;
  logic [7:0] data;
  logic [7:0] key_code;
  logic       key_down;
  logic [7:0] random_byte;
  modport source (output valid, cmd, address, data, key_code, key_down, random_byte,
                  input ready);
  modport sink (input valid, cmd, address, data, key_code, key_down, random_byte,
                output ready);
endinterface

interface c8ic_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [7:0]  read_data;
  logic [7:0]  flag_value;
  logic [1:0]  status;
  modport source (output valid, program_counter, read_data, flag_value, status,
                  input ready);
  modport sink (input valid, program_counter, read_data, flag_value, status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/c8ic_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module c8ic_ctrl
  import c8ic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_cmd,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire c8ic_stat_t stat,
  output c8ic_cmd_t       cmd
);

  c8ic_state_t       state_r, state_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [MEM_AW-1:0] clr_r, clr_nxt;
  logic              ov_r, ov_nxt;
  logic              out_free;
  logic [3:0]        grp, nx, n;
  logic [7:0]        nn;

  assign grp = stat.op[15:12];
  assign nx  = stat.op[11:8];
  assign n   = stat.op[3:0];
  assign nn  = stat.op[7:0];
  assign out_free = !ov_r || out_ready;
  assign out_valid = ov_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == MEM_AW'(MEM_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = (in_cmd == CMD_STEP) ? S_F0 : S_RD;
      S_RD:    state_nxt = S_MISC;
      S_MISC:  state_nxt = S_OUT;
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_EXEC;
      S_EXEC: begin
        if (grp == GRP_DRAW) state_nxt = (n == 4'd0) ? S_DFIN : S_DI;
        else if (grp == GRP_F && nn == OP_STORE) state_nxt = S_ST;
        else if (grp == GRP_F && nn == OP_LOAD) state_nxt = S_LI;
        else state_nxt = S_OUT;
      end
      S_DI:    state_nxt = S_DD;
      S_DD:    state_nxt = (cnt_r + 4'd1 == n) ? S_DFIN : S_DI;
      S_DFIN:  state_nxt = S_OUT;
      S_ST:    if (cnt_r == nx) state_nxt = S_OUT;
      S_LI:    state_nxt = S_LD;
      S_LD:    state_nxt = (cnt_r == nx) ? S_OUT : S_LI;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd = '0;
    cmd.msel = MA_PC;
    cmd.cnt = cnt_r;
    cmd.clr_addr = clr_r;
    in_ready = 1'b0;
    cnt_nxt = cnt_r;
    clr_nxt = clr_r;
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.msel = MA_CLEAR;
        cmd.clear = 1'b1;
        clr_nxt = clr_r + MEM_AW'(1);
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      S_RD:   cmd.msel = MA_ITEM;
      S_MISC: begin
        cmd.msel = MA_ITEM;
        cmd.misc = 1'b1;
      end
      S_F0:   cmd.msel = MA_PC;
      S_F1: begin
        cmd.msel = MA_PC1;
        cmd.cap_hi = 1'b1;
      end
      S_F2:   cmd.cap_lo = 1'b1;
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_nxt = 4'd0;
      end
      S_DI:   cmd.msel = MA_IDX;
      S_DD: begin
        cmd.draw_row = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
      end
      S_DFIN: cmd.draw_fin = 1'b1;
      S_ST: begin
        cmd.msel = MA_IDX;
        cmd.store = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
      end
      S_LI:   cmd.msel = MA_IDX;
      S_LD: begin
        cmd.load_reg = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          ov_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/c8ic_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module c8ic_dp
  import c8ic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire c8ic_cmd_t   cmd,
  output c8ic_stat_t       stat,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_data,
  input  wire logic [7:0]  in_key_code,
  input  wire logic        in_key_down,
  input  wire logic [7:0]  in_random_byte,
  output logic [11:0]      out_program_counter,
  output logic [7:0]       out_read_data,
  output logic [7:0]       out_flag_value,
  output logic [1:0]       out_status
);

  // latched request
  logic [2:0]  cmd_r;
  logic [11:0] addr_r;
  logic [7:0]  data_r, key_r, rnd_r;
  logic        down_r;

  // architectural state
  logic [7:0]          mem [MEM_BYTES];
  logic [7:0]          v_r [16];
  logic [11:0]         stk_r [STACK_DEPTH];
  logic [SCREEN_W-1:0] frame_r [SCREEN_H];
  logic [NUM_KEYS-1:0] keys_r;
  logic [11:0]         i_r, pc_r;
  logic [SP_W-1:0]     sp_r;

  // working registers
  logic [15:0] op_r;
  logic [7:0]  rdata_r, rd_r, x0_r, y0_r;
  logic [1:0]  st_r;
  logic        hit_r;

  // memory port
  logic [11:0]       ma;
  logic [MEM_AW-1:0] mem_a;
  logic              mem_we;
  logic [7:0]        mem_wd;

  always_comb begin
    case (cmd.msel)
      MA_ITEM: ma = addr_r;
      MA_PC:   ma = pc_r;
      MA_PC1:  ma = pc_r + 12'd1;
      MA_IDX:  ma = i_r + {8'd0, cmd.cnt};
      default: ma = 12'd0;
    endcase
    mem_a = (cmd.msel == MA_CLEAR) ? cmd.clr_addr : mem_idx(ma);
    mem_we = cmd.clear || cmd.store || (cmd.misc && cmd_r == CMD_WRITE);
    if (cmd.store) mem_wd = v_r[cmd.cnt];
    else if (cmd.clear) mem_wd = 8'd0;
    else mem_wd = data_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    rdata_r <= mem[mem_a];
  end

  assign stat.op = op_r;

  // instruction execute
  logic [3:0]      nib, nx, ny, n;
  logic [7:0]      nn, vx, vy;
  logic [11:0]     nnn, pc2, pc4;
  logic [8:0]      add9;
  logic [11:0]     ex_pc;
  logic [1:0]      ex_st;
  logic            vx_we, vf_we, i_we, sp_we, push;
  logic [7:0]      vx_val, vf_val;
  logic [11:0]     i_val;
  logic [SP_W-1:0] sp_val;
  logic [KEY_W-1:0] vkey;

  always_comb begin
    nib = op_r[15:12];
    nx = op_r[11:8];
    ny = op_r[7:4];
    n = op_r[3:0];
    nn = op_r[7:0];
    nnn = op_r[11:0];
    vx = v_r[nx];
    vy = v_r[ny];
    pc2 = pc_r + 12'd2;
    pc4 = pc_r + 12'd4;
    add9 = {1'b0, vx} + {1'b0, vy};
    vkey = KEY_W'(vx);
    ex_pc = pc2;
    ex_st = ST_OK;
    vx_we = 1'b0;
    vx_val = 8'd0;
    vf_we = 1'b0;
    vf_val = 8'd0;
    i_we = 1'b0;
    i_val = nnn;
    sp_we = 1'b0;
    sp_val = sp_r;
    push = 1'b0;
    case (nib)
      4'h0: begin
        if (op_r == OP_RETURN) begin
          sp_we = 1'b1;
          sp_val = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - SP_W'(1);
          ex_pc = stk_r[sp_val] + 12'd2;
          if (sp_r == '0) ex_st = ST_WRAP;
        end else begin
          ex_pc = pc_r;
          ex_st = ST_UNIMPL;
        end
      end
      4'h1: ex_pc = nnn;
      4'h2: begin
        push = 1'b1;
        sp_we = 1'b1;
        sp_val = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + SP_W'(1);
        if (sp_r == SP_W'(STACK_DEPTH - 1)) ex_st = ST_WRAP;
        ex_pc = nnn;
      end
      4'h3: ex_pc = (vx == nn) ? pc4 : pc2;
      4'h4: ex_pc = (vx != nn) ? pc4 : pc2;
      4'h5: ex_pc = (vx == vy) ? pc4 : pc2;
      4'h9: ex_pc = (vx != vy) ? pc4 : pc2;
      4'h6: begin
        vx_we = 1'b1;
        vx_val = nn;
      end
      4'h7: begin
        vx_we = 1'b1;
        vx_val = vx + nn;
      end
      4'h8: begin
        vx_we = 1'b1;
        case (n)
          4'h0: vx_val = vy;
          4'h1: vx_val = vx | vy;
          4'h2: vx_val = vx & vy;
          4'h3: vx_val = vx ^ vy;
          4'h4: begin
            vx_val = add9[7:0];
            vf_we = 1'b1;
            vf_val = {7'd0, add9[8]};
          end
          4'h5: begin
            vx_val = vx - vy;
            vf_we = 1'b1;
            vf_val = {7'd0, vx >= vy};
          end
          4'h6: begin
            vx_val = {1'b0, vx[7:1]};
            vf_we = 1'b1;
            vf_val = {7'd0, vx[0]};
          end
          4'h7: begin
            vx_val = vy - vx;
            vf_we = 1'b1;
            vf_val = {7'd0, vy >= vx};
          end
          4'hE: begin
            vx_val = {vx[6:0], 1'b0};
            vf_we = 1'b1;
            vf_val = {7'd0, vx[7]};
          end
          default: begin
            vx_we = 1'b0;
            ex_pc = pc_r;
            ex_st = ST_UNIMPL;
          end
        endcase
      end
      4'hA: i_we = 1'b1;
      4'hB: begin
        i_we = 1'b1;
        i_val = nnn + {4'd0, v_r[0]};
      end
      4'hC: begin
        vx_we = 1'b1;
        vx_val = rnd_r & nn;
      end
      4'hD: ex_pc = pc2;
      4'hE: begin
        if (nn == OP_KEYSKIP) ex_pc = keys_r[vkey] ? pc4 : pc2;
        else begin
          ex_pc = pc_r;
          ex_st = ST_UNIMPL;
        end
      end
      default: begin
        if (nn != OP_STORE && nn != OP_LOAD) begin
          ex_pc = pc_r;
          ex_st = ST_UNIMPL;
        end
      end
    endcase
  end

  // sprite row: XOR mask with column wrap
  logic [SCREEN_W-1:0] mask;
  logic [SH_W-1:0]     row_idx;
  logic [SW_W-1:0]     col;

  always_comb begin
    mask = '0;
    col = '0;
    row_idx = SH_W'({1'b0, y0_r} + {5'd0, cmd.cnt});
    for (int c = 0; c < 8; c++) begin
      col = SW_W'({1'b0, x0_r} + 9'(c));
      mask[col] = mask[col] | rdata_r[7 - c];
    end
  end

  // request latch and opcode capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      addr_r <= in_address;
      data_r <= in_data;
      key_r <= in_key_code;
      down_r <= in_key_down;
      rnd_r <= in_random_byte;
    end
    if (cmd.cap_hi) op_r[15:8] <= rdata_r;
    if (cmd.cap_lo) op_r[7:0] <= rdata_r;
    if (cmd.exec) begin
      x0_r <= vx;
      y0_r <= vy;
    end
  end

  // architectural state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) v_r[k] <= 8'd0;
      for (int k = 0; k < STACK_DEPTH; k++) stk_r[k] <= 12'd0;
      for (int k = 0; k < SCREEN_H; k++) frame_r[k] <= '0;
      keys_r <= '0;
      i_r <= 12'd0;
      pc_r <= 12'd0;
      sp_r <= '0;
      rd_r <= 8'd0;
      st_r <= ST_OK;
      hit_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pc_r <= ex_pc;
        st_r <= ex_st;
        rd_r <= 8'd0;
        hit_r <= 1'b0;
        // the flag takes VF when X is F
        if (vx_we && !(vf_we && nx == 4'hF)) v_r[nx] <= vx_val;
        if (vf_we) v_r[15] <= vf_val;
        if (i_we) i_r <= i_val;
        if (sp_we) sp_r <= sp_val;
        if (push) stk_r[sp_r] <= pc_r;
      end
      if (cmd.draw_row) begin
        frame_r[row_idx] <= frame_r[row_idx] ^ mask;
        hit_r <= hit_r | (|(frame_r[row_idx] & mask));
      end
      if (cmd.draw_fin) v_r[15] <= {7'd0, hit_r};
      if (cmd.load_reg) v_r[cmd.cnt] <= rdata_r;
      if (cmd.misc) begin
        st_r <= ST_OK;
        rd_r <= (cmd_r == CMD_READ) ? rdata_r : 8'd0;
        if (cmd_r == CMD_KEY) keys_r[KEY_W'(key_r)] <= down_r;
        if (cmd_r == CMD_RESET_PC) pc_r <= PROGRAM_START[11:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_program_counter <= pc_r;
      out_read_data <= rd_r;
      out_flag_value <= v_r[15];
      out_status <= st_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/chip8_instruction_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// CHIP-8 style execution core.
// in_ch carries one request: cmd (step, write byte, key event, read byte,
// reset pc) with address, data, key_code, key_down and random_byte.
// out_ch returns exactly one result per request: program counter, read byte,
// VF and a status code (ok, unimplemented opcode, stack wrapped).
// A read/write/key/reset-pc request passes through a memory read, its action
// and the result load; a step fetches two opcode bytes and then executes; a
// sprite draw adds an index and a data state per row plus a finish state, FX55
// stores V0..VX in turn and FX65 loads them with an address and a data state
// per register. The core returns to idle before the next request is taken; the single memory port sets these steps.
// One request is in work at a time.
// A finished result sits in the output register; the next request is taken
// while it waits, and the core holds at the end of that request until the
// receiver takes the earlier result.
// Reset (synchronous, rst_n low) clears registers, stack, keys and display,
// then sweeps all MEM_BYTES (4096 here) bytes of main memory to zero, one byte
// per cycle; in_ch.ready stays low during the sweep.
module chip8_instruction_core
  import c8ic_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  c8ic_in_if.sink     in_ch,
  c8ic_out_if.source  out_ch
);

  c8ic_cmd_t  cmd;
  c8ic_stat_t stat;

  c8ic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  c8ic_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_cmd              (in_ch.cmd),
    .in_address          (in_ch.address),
    .in_data             (in_ch.data),
    .in_key_code         (in_ch.key_code),
    .in_key_down         (in_ch.key_down),
    .in_random_byte      (in_ch.random_byte),
    .out_program_counter (out_ch.program_counter),
    .out_read_data       (out_ch.read_data),
    .out_flag_value      (out_ch.flag_value),
    .out_status          (out_ch.status)
  );

endmodule
`default_nettype wire
